// ----- sv/crt_flash_coincidence_classifier_top_assert.svh -----
// Assertion macros for the flash coincidence classifier.
`ifndef CRT_FLASH_COINCIDENCE_CLASSIFIER_TOP_ASSERT_SVH
`define CRT_FLASH_COINCIDENCE_CLASSIFIER_TOP_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define CFCC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cfcc assertion failed");

// Next-cycle implication.
`define CFCC_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cfcc assertion failed");

`endif

// ----- sv/cfcc_pkg.sv -----
// Shared types, codes and the match classification for the coincidence classifier.
package cfcc_pkg;

  localparam int unsigned TopMaxPlane  = 36;
  localparam int unsigned SideMaxPlane = 49;
  localparam int unsigned FifoDepth    = 4;
  localparam int unsigned NumCounts    = 6;

  localparam logic [1:0] REGION_TOP    = 2'd0;
  localparam logic [1:0] REGION_SIDE   = 2'd1;
  localparam logic [1:0] REGION_BOTTOM = 2'd2;

  localparam logic [1:0] CFG_WINDOW    = 2'd0;
  localparam logic [1:0] CFG_REAL_MODE = 2'd1;
  localparam logic [1:0] CFG_OFFSET    = 2'd2;
  localparam logic [1:0] CFG_BOTTOM_EN = 2'd3;

  localparam logic [3:0] CLASS_NONE                   = 4'd0;
  localparam logic [3:0] CLASS_EXIT_BOTTOM            = 4'd1;
  localparam logic [3:0] CLASS_ENTER_BOTTOM           = 4'd2;
  localparam logic [3:0] CLASS_OTHERS                 = 4'd3;
  localparam logic [3:0] CLASS_ENTER_TOP_EXIT_BOTTOM  = 4'd4;
  localparam logic [3:0] CLASS_ENTER_TOP              = 4'd5;
  localparam logic [3:0] CLASS_ENTER_SIDE_EXIT_BOTTOM = 4'd6;
  localparam logic [3:0] CLASS_ENTER_SIDE             = 4'd7;
  localparam logic [3:0] CLASS_ENTER_TOP_EXIT_SIDE    = 4'd8;
  localparam logic [3:0] CLASS_EXIT_TOP_ENTER_BOTTOM  = 4'd9;
  localparam logic [3:0] CLASS_EXIT_TOP               = 4'd10;
  localparam logic [3:0] CLASS_EXIT_SIDE_ENTER_BOTTOM = 4'd11;
  localparam logic [3:0] CLASS_EXIT_SIDE              = 4'd12;
  localparam logic [3:0] CLASS_ENTER_TOP_MULTI        = 4'd13;
  localparam logic [3:0] CLASS_ENTER_TOP_EXIT_SIDE_MULTI = 4'd14;

  // Counter slots: top enter, top exit, side enter, side exit, bottom enter, bottom exit
  localparam int unsigned TEN = 0;
  localparam int unsigned TEX = 1;
  localparam int unsigned SEN = 2;
  localparam int unsigned SEX = 3;
  localparam int unsigned BEN = 4;
  localparam int unsigned BEX = 5;

  typedef struct packed {
    logic [31:0] window;
    logic        real_mode;
    logic [61:0] offset;
    logic        bottom_en;
  } cfcc_cfg_t;

  typedef struct packed {
    logic               first;
    logic               last;
    logic               present;
    logic signed [40:0] flash_time;
    logic signed [31:0] fine_time;
    logic        [61:0] raw_time;
    logic        [6:0]  plane;
  } cfcc_in_t;

  // One classified hit on its way from the front end to the counters
  typedef struct packed {
    logic signed [62:0] tof;
    logic               matched;
    logic               entering;
    logic [1:0]         region;
    logic               first;
    logic               last;
  } cfcc_item_t;

  typedef struct packed {
    logic signed [62:0] tof;
    logic               matched;
    logic               entering;
    logic [1:0]         region;
    logic               class_valid;
    logic [3:0]         match_class;
  } cfcc_res_t;

  // z: count is zero, o: count is exactly one, per counter slot
  function automatic logic [3:0] classify(input logic [NumCounts-1:0] z,
                                          input logic [NumCounts-1:0] o);
    logic [3:0] c;
    c = CLASS_OTHERS;
    if (z[TEN] && z[SEN] && z[TEX] && z[SEX]) begin
      if (z[BEX] && z[BEN])       c = CLASS_NONE;
      else if (!z[BEX] && z[BEN]) c = CLASS_EXIT_BOTTOM;
      else if (z[BEX] && !z[BEN]) c = CLASS_ENTER_BOTTOM;
      else                        c = CLASS_OTHERS;
    end else if (o[TEN] && z[SEN] && z[TEX] && z[SEX]) begin
      c = (o[BEX] && z[BEN]) ? CLASS_ENTER_TOP_EXIT_BOTTOM : CLASS_ENTER_TOP;
    end else if (z[TEN] && o[SEN] && z[TEX] && z[SEX]) begin
      c = (o[BEX] && z[BEN]) ? CLASS_ENTER_SIDE_EXIT_BOTTOM : CLASS_ENTER_SIDE;
    end else if (o[TEN] && z[SEN] && z[TEX] && o[SEX]) begin
      c = CLASS_ENTER_TOP_EXIT_SIDE;
    end else if (z[TEN] && z[SEN] && o[TEX] && z[SEX]) begin
      c = (z[BEX] && o[BEN]) ? CLASS_EXIT_TOP_ENTER_BOTTOM : CLASS_EXIT_TOP;
    end else if (z[TEN] && z[SEN] && z[TEX] && o[SEX]) begin
      c = (z[BEX] && o[BEN]) ? CLASS_EXIT_SIDE_ENTER_BOTTOM : CLASS_EXIT_SIDE;
    end else if (!z[TEN] && !z[SEN] && z[TEX] && z[SEX]) begin
      c = CLASS_ENTER_TOP_MULTI;
    end else if (!z[TEN] && !z[SEN] && z[TEX] && !z[SEX]) begin
      c = CLASS_ENTER_TOP_EXIT_SIDE_MULTI;
    end
    return c;
  endfunction

endpackage

// ----- sv/cfcc_front.sv -----
// Front end: hit time, time of flight, window test and region per item.
module cfcc_front import cfcc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfcc_cfg_t  cfg_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  cfcc_in_t   in_i,
  output logic       push_o,
  output cfcc_item_t item_o,
  input  logic       full_i
);

  logic               v1_q, v2_q;
  logic               adv1, adv2;
  logic signed [62:0] hit_time_d, hit_time_q;
  logic signed [40:0] flash_q;
  logic               first1_q, last1_q, present1_q, skip1_q;
  logic [1:0]         region1_q, region1_d;
  logic               skip1_d;
  logic signed [63:0] tof_d, tof_q, ntof_d, ntof_q;
  logic               first2_q, last2_q, present2_q, skip2_q;
  logic [1:0]         region2_q;
  logic        [63:0] mag;
  logic               in_win;
  logic               matched;
  logic signed [62:0] tof_sat;

  assign adv2       = !v2_q || !full_i;
  assign adv1       = !v1_q || adv2;
  assign in_ready_o = adv1;
  assign push_o     = v2_q && !full_i;

  always_comb begin
    if (cfg_i.real_mode) begin
      hit_time_d = {{31{in_i.fine_time[31]}}, in_i.fine_time};
    end else begin
      hit_time_d = {1'b0, in_i.raw_time} - {1'b0, cfg_i.offset};
    end
    if (in_i.plane > 7'(SideMaxPlane)) begin
      region1_d = REGION_BOTTOM;
    end else if (in_i.plane > 7'(TopMaxPlane)) begin
      region1_d = REGION_SIDE;
    end else begin
      region1_d = REGION_TOP;
    end
    skip1_d = (region1_d == REGION_BOTTOM) && !cfg_i.bottom_en;
  end

  // both signs of the difference are formed so the magnitude needs no negation later
  assign tof_d  = {hit_time_q[62], hit_time_q} - {{23{flash_q[40]}}, flash_q};
  assign ntof_d = {{23{flash_q[40]}}, flash_q} - {hit_time_q[62], hit_time_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= in_valid_i;
      if (adv2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1 && in_valid_i) begin
      hit_time_q <= hit_time_d;
      flash_q    <= in_i.flash_time;
      first1_q   <= in_i.first;
      last1_q    <= in_i.last;
      present1_q <= in_i.present;
      region1_q  <= region1_d;
      skip1_q    <= skip1_d;
    end
    if (adv2 && v1_q) begin
      tof_q      <= tof_d;
      ntof_q     <= ntof_d;
      first2_q   <= first1_q;
      last2_q    <= last1_q;
      present2_q <= present1_q;
      region2_q  <= region1_q;
      skip2_q    <= skip1_q;
    end
  end

  assign mag     = tof_q[63] ? ntof_q : tof_q;
  assign in_win  = mag < {32'd0, cfg_i.window};
  assign matched = present2_q && !skip2_q && in_win;

  // clamp to 63 bits when the top two bits disagree
  always_comb begin
    if (tof_q[63] == tof_q[62]) begin
      tof_sat = tof_q[62:0];
    end else if (!tof_q[63]) begin
      tof_sat = {1'b0, {62{1'b1}}};
    end else begin
      tof_sat = {1'b1, {62{1'b0}}};
    end
  end

  always_comb begin
    item_o.tof      = present2_q ? tof_sat : '0;
    item_o.matched  = matched;
    item_o.entering = matched && tof_q[63];
    item_o.region   = matched ? region2_q : REGION_TOP;
    item_o.first    = first2_q;
    item_o.last     = last2_q;
  end

endmodule

// ----- sv/cfcc_fifo.sv -----
// Short queue of classified hits between front end and counters.
module cfcc_fifo import cfcc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  cfcc_item_t item_i,
  output logic       full_o,
  input  logic       pop_i,
  output cfcc_item_t item_o,
  output logic       empty_o
);

  localparam int unsigned PtrW = $clog2(FifoDepth);

  cfcc_item_t       mem_q [FifoDepth];
  logic [PtrW-1:0]  wr_q, rd_q;
  logic [PtrW:0]    cnt_q;

  assign full_o  = cnt_q == (PtrW+1)'(FifoDepth);
  assign empty_o = cnt_q == '0;
  assign item_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= item_i;
  end

endmodule

// ----- sv/cfcc_back.sv -----
// Back end: per-region entering/exiting counters, flash classification, output register.
module cfcc_back import cfcc_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfcc_item_t item_i,
  input  logic       empty_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output cfcc_res_t  res_o
);

  logic [COUNT_WIDTH-1:0] cnt_q [NumCounts];
  logic [COUNT_WIDTH-1:0] cnt_d [NumCounts];
  logic [NumCounts-1:0]   is_zero, is_one;
  logic [2:0]             slot;
  logic                   out_v_q;
  cfcc_res_t              res_q, res_d;

  assign pop_o       = !empty_i && (!out_v_q || out_ready_i);
  assign out_valid_o = out_v_q;
  assign res_o       = res_q;
  // slot = region * 2 + exiting
  assign slot        = {item_i.region, !item_i.entering};

  always_comb begin
    for (int i = 0; i < NumCounts; i++) begin
      cnt_d[i] = item_i.first ? '0 : cnt_q[i];
      if (item_i.matched && slot == 3'(i) && cnt_d[i] != '1) begin
        cnt_d[i] = cnt_d[i] + 1'b1;
      end
      is_zero[i] = cnt_d[i] == '0;
      is_one[i]  = cnt_d[i] == COUNT_WIDTH'(1);
    end
    res_d.tof         = item_i.tof;
    res_d.matched     = item_i.matched;
    res_d.entering    = item_i.entering;
    res_d.region      = item_i.region;
    res_d.class_valid = item_i.last;
    res_d.match_class = item_i.last ? classify(is_zero, is_one) : CLASS_NONE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      for (int i = 0; i < NumCounts; i++) cnt_q[i] <= '0;
    end else begin
      if (pop_o) begin
        out_v_q <= 1'b1;
        for (int i = 0; i < NumCounts; i++) cnt_q[i] <= cnt_d[i];
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) res_q <= res_d;
  end

endmodule

// ----- sv/crt_flash_coincidence_classifier_top.sv -----
// Flash coincidence classifier: one result per hit item, match class on each flash's last item.
// Takes one item per clock and keeps that rate as long as results are taken. An item's
// result passes two front-end stages (hit time, then time of flight and window test), a
// four-entry queue and the output register that follows the counter update. The queue
// lets input keep flowing while the output side stalls; once it is full and both
// front-end stages hold items, tready falls. Configuration writes are always taken and
// are meant for an idle block.
module crt_flash_coincidence_classifier_top import cfcc_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // flash_time_ns[40:0], fine_time_ns[72:41], raw_timestamp_ns[134:73], plane[141:135]
  input  logic [143:0] s_axis_tdata_i,
  input  logic         s_axis_tlast_i,   // last_of_flash
  // first_of_flash[0], hit_present[1]
  input  logic [1:0]   s_axis_tuser_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // time_of_flight_ns[62:0], hit_matched[63], entering[64], region[66:65],
  // match_class[70:67]
  output logic [71:0]  m_axis_tdata_o,
  output logic         m_axis_tlast_o,   // class_valid
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_index_i,
  input  logic [63:0]  cfg_data_i
);

  `include "crt_flash_coincidence_classifier_top_assert.svh"

  cfcc_cfg_t  cfg_q;
  cfcc_in_t   in_item;
  cfcc_item_t front_item, fifo_item;
  cfcc_res_t  res;
  logic       push, full, pop, empty;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window    <= 32'd100;
      cfg_q.real_mode <= 1'b1;
      cfg_q.offset    <= '0;
      cfg_q.bottom_en <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_WINDOW:    cfg_q.window    <= cfg_data_i[31:0];
        CFG_REAL_MODE: cfg_q.real_mode <= cfg_data_i[0];
        CFG_OFFSET:    cfg_q.offset    <= cfg_data_i[61:0];
        CFG_BOTTOM_EN: cfg_q.bottom_en <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    in_item.first      = s_axis_tuser_i[0];
    in_item.last       = s_axis_tlast_i;
    in_item.present    = s_axis_tuser_i[1];
    in_item.flash_time = s_axis_tdata_i[40:0];
    in_item.fine_time  = s_axis_tdata_i[72:41];
    in_item.raw_time   = s_axis_tdata_i[134:73];
    in_item.plane      = s_axis_tdata_i[141:135];
  end

  cfcc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_i       (in_item),
    .push_o     (push),
    .item_o     (front_item),
    .full_i     (full)
  );

  cfcc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (full),
    .pop_i   (pop),
    .item_o  (fifo_item),
    .empty_o (empty)
  );

  cfcc_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (fifo_item),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .res_o       (res)
  );

  assign m_axis_tdata_o = {1'b0, res.match_class, res.region, res.entering, res.matched,
                           res.tof};
  assign m_axis_tlast_o = res.class_valid;

  `CFCC_ASSERT_IMP(a_class_only_last, m_axis_tvalid_o && !m_axis_tlast_o,
                   res.match_class == CLASS_NONE)
  `CFCC_ASSERT_IMP(a_unmatched_clear, m_axis_tvalid_o && !res.matched,
                   !res.entering && res.region == REGION_TOP)
  `CFCC_ASSERT_IMP(a_region_legal, m_axis_tvalid_o && res.matched,
                   res.region == REGION_TOP || res.region == REGION_SIDE ||
                   res.region == REGION_BOTTOM)
  `CFCC_ASSERT_IMP(a_entering_sign, m_axis_tvalid_o && res.matched,
                   res.entering == res.tof[62])

endmodule
